### design/lpht_pkg.sv
// Types and constants shared by the linear probing hash table.
`default_nettype none

package lpht_pkg;

   // Field widths of the request and response
   localparam int CMD_W   = 2;
   localparam int KEY_W   = 16;
   localparam int SLOT_W  = 10;
   localparam int SIZE_W  = 11;
   localparam int STAT_W  = 2;
   localparam int PROBE_W = 11;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_DEPTH - 1);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [KEY_W-1:0]  key_value;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  slot;
      logic [KEY_W-1:0]   stored_key;
      logic               occupied;
      logic [PROBE_W-1:0] success_probes;
      logic [PROBE_W-1:0] fail_probes;
   } rsp_type;

   // One slot as held in the table memory
   typedef struct packed {
      logic               valid;
      logic [PROBE_W-1:0] probes;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_WALK
   } state_type;

   // What the walk is doing with each slot it reads
   typedef enum logic [1:0] {
      M_SEARCH,
      M_QUERY,
      M_FAIL
   } mode_type;

endpackage

`default_nettype wire

### design/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing, held in one slot memory.
// Insert: restoring division gives the home slot, the walk probes to an empty slot, then counts the run
//   after it; query reads an in-range slot and, if occupied, counts the run after it; clear sweeps every slot.
// One request at a time: busy stays high until its result strobe; the walk reads one slot a cycle.
// Result is strobed for one cycle on rsp_valid; the receiver cannot stall it.
// Reset: synchronous; a sweep empties the memory with busy high, table_size = 1024.
`default_nettype none

module linear_probe_hash_table (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire lpht_pkg::req_type       req_data,
   output logic                         rsp_valid,
   output lpht_pkg::rsp_type            rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [lpht_pkg::SIZE_W-1:0]   csr_data
);

   import lpht_pkg::*;

   // Slot memory
   entry_type slot_mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;

   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SLOT_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [SLOT_W-1:0]  chk_pos_ff, chk_pos_in;
   logic [SLOT_W-1:0]  home_ff, home_in;
   logic [SLOT_W-1:0]  rem_ff, rem_in;
   logic [KEY_W-1:0]   div_key_ff, div_key_in;
   logic [3:0]         bit_ff, bit_in;
   logic [PROBE_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0]  left_ff, left_in;
   logic               data_vld_ff;
   logic               clr_rsp_ff, clr_rsp_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               rd_en;
   logic               mem_we;
   logic [SLOT_W-1:0]  mem_wa;
   entry_type          mem_wd;
   logic               walk_done;
   logic [SIZE_W-1:0]  rd_inc;
   logic [SLOT_W-1:0]  rd_next;
   logic [SIZE_W-1:0]  size_m1;
   logic [SIZE_W-1:0]  rem_shift;
   logic [SIZE_W-1:0]  rem_sub;
   logic [SLOT_W-1:0]  rem_new;
   logic               idx_range;

   assign accept = start & ~busy;

   // Slot pointer steps forward and wraps at the table size
   assign rd_inc  = {1'b0, rd_pos_ff} + SIZE_W'(1);
   assign rd_next = (rd_inc >= size_ff) ? '0 : rd_inc[SLOT_W-1:0];
   assign size_m1 = size_ff - SIZE_W'(1);

   // One remainder bit per cycle: key mod table_size
   assign rem_shift = {rem_ff, div_key_ff[KEY_W-1]};
   assign rem_sub   = rem_shift - size_ff;
   assign rem_new   = (rem_shift >= size_ff) ? rem_sub[SLOT_W-1:0] : rem_shift[SLOT_W-1:0];

   assign idx_range = ({1'b0, req_data.slot_index} >= size_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (rd_pos_ff == LAST_SLOT) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_CLEAR:  state_in = S_CLEAR;
                  CMD_INSERT: state_in = S_HASH;
                  CMD_QUERY:  state_in = idx_range ? S_IDLE : S_WALK;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_HASH: begin
            if (bit_ff == 4'd15) state_in = S_WALK;
         end
         S_WALK: begin
            if (walk_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State machine outputs; a size write never shares an edge with a request
   always_comb begin
      busy      = (state_ff != S_IDLE);
      csr_ready = (state_ff == S_IDLE) && !start;
      rd_en     = (state_ff == S_WALK);
   end

   // Datapath
   always_comb begin
      mode_in      = mode_ff;
      size_in      = size_ff;
      rd_pos_in    = rd_pos_ff;
      chk_pos_in   = chk_pos_ff;
      home_in      = home_ff;
      rem_in       = rem_ff;
      div_key_in   = div_key_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = rd_pos_ff;
      mem_wd       = '0;
      walk_done    = 1'b0;

      // Size register, clamped to 1..TABLE_DEPTH on write
      if (csr_valid && csr_ready) begin
         if (csr_data == '0)          size_in = SIZE_W'(1);
         else if (csr_data > SIZE_MAX) size_in = SIZE_MAX;
         else                          size_in = csr_data;
      end

      case (state_ff)
         // Sweep every slot empty
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wa    = rd_pos_ff;
            rd_pos_in = rd_pos_ff + SLOT_W'(1);
            if (rd_pos_ff == LAST_SLOT) begin
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end

         // Take a request
         S_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_CLEAR: begin
                     rd_pos_in  = '0;
                     clr_rsp_in = 1'b1;
                  end
                  CMD_INSERT: begin
                     div_key_in        = req_data.key_value;
                     rem_in            = '0;
                     bit_in            = '0;
                     rsp_in            = '0;
                     rsp_in.stored_key = req_data.key_value;
                  end
                  CMD_QUERY: begin
                     rsp_in      = '0;
                     rsp_in.slot = req_data.slot_index;
                     if (idx_range) begin
                        rsp_in.status = STAT_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rd_pos_in = req_data.slot_index;
                        mode_in   = M_QUERY;
                     end
                  end
                  default: begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // Home slot by restoring division
         S_HASH: begin
            rem_in     = rem_new;
            div_key_in = {div_key_ff[KEY_W-2:0], 1'b0};
            bit_in     = bit_ff + 4'd1;
            if (bit_ff == 4'd15) begin
               rd_pos_in = rem_new;
               home_in   = rem_new;
               mode_in   = M_SEARCH;
               cnt_in    = PROBE_W'(1);
               left_in   = size_ff;
            end
         end

         // Stream one slot read a cycle, check the slot read last cycle
         S_WALK: begin
            rd_pos_in  = rd_next;
            chk_pos_in = rd_pos_ff;
            if (data_vld_ff) begin
               case (mode_ff)
                  M_SEARCH: begin
                     if (rd_data_ff.valid) begin
                        cnt_in  = cnt_ff + PROBE_W'(1);
                        left_in = left_ff - SIZE_W'(1);
                        if (left_ff == SIZE_W'(1)) begin
                           rsp_in        = '0;
                           rsp_in.status = STAT_FULL;
                           rsp_in.slot   = home_ff;
                           rsp_valid_in  = 1'b1;
                           walk_done     = 1'b1;
                        end
                     end else begin
                        // Empty slot: place the key, then count the run behind it
                        mem_we                = 1'b1;
                        mem_wa                = chk_pos_ff;
                        mem_wd.valid          = 1'b1;
                        mem_wd.probes         = cnt_ff;
                        mem_wd.key            = rsp_ff.stored_key;
                        rsp_in.status         = STAT_OK;
                        rsp_in.slot           = chk_pos_ff;
                        rsp_in.occupied       = 1'b1;
                        rsp_in.success_probes = cnt_ff;
                        mode_in               = M_FAIL;
                        cnt_in                = PROBE_W'(2);
                        left_in               = size_m1;
                        if (size_m1 == '0) begin
                           rsp_in.fail_probes = PROBE_W'(2);
                           rsp_valid_in       = 1'b1;
                           walk_done          = 1'b1;
                        end
                     end
                  end
                  M_QUERY: begin
                     if (rd_data_ff.valid) begin
                        rsp_in.stored_key     = rd_data_ff.key;
                        rsp_in.occupied       = 1'b1;
                        rsp_in.success_probes = rd_data_ff.probes;
                        mode_in               = M_FAIL;
                        cnt_in                = PROBE_W'(2);
                        left_in               = size_m1;
                        if (size_m1 == '0) begin
                           rsp_in.fail_probes = PROBE_W'(2);
                           rsp_valid_in       = 1'b1;
                           walk_done          = 1'b1;
                        end
                     end else begin
                        rsp_in.fail_probes = PROBE_W'(1);
                        rsp_valid_in       = 1'b1;
                        walk_done          = 1'b1;
                     end
                  end
                  M_FAIL: begin
                     if (rd_data_ff.valid) begin
                        cnt_in  = cnt_ff + PROBE_W'(1);
                        left_in = left_ff - SIZE_W'(1);
                        if (left_ff == SIZE_W'(1)) begin
                           rsp_in.fail_probes = cnt_ff + PROBE_W'(1);
                           rsp_valid_in       = 1'b1;
                           walk_done          = 1'b1;
                        end
                     end else begin
                        rsp_in.fail_probes = cnt_ff;
                        rsp_valid_in       = 1'b1;
                        walk_done          = 1'b1;
                     end
                  end
                  default: begin
                     walk_done = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            walk_done = 1'b0;
         end
      endcase
   end

   // Slot memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem[rd_pos_ff];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         size_ff      <= SIZE_MAX;
         rd_pos_ff    <= '0;
         data_vld_ff  <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rd_pos_ff    <= rd_pos_in;
         data_vld_ff  <= rd_en & ~walk_done;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      chk_pos_ff <= chk_pos_in;
      home_ff    <= home_in;
      rem_ff     <= rem_in;
      div_key_ff <= div_key_in;
      bit_ff     <= bit_in;
      cnt_ff     <= cnt_in;
      left_ff    <= left_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // The memory is written only by the sweep or by a placing insert
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_WALK))
      else $error("slot memory written outside sweep or walk");

   // A result is only strobed once the block is back at rest
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobed while a request is in flight");

   // The partial remainder stays below the modulus
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HASH) |-> ({1'b0, rem_ff} < size_ff))
      else $error("remainder out of range");

   // A counted walk never checks beyond its slot budget
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && data_vld_ff && mode_ff != M_QUERY) |-> (left_ff != '0))
      else $error("walk ran past the table size");

   // The failure count is capped at table_size + 1
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_ff.fail_probes} <= {1'b0, size_ff} + 12'd1))
      else $error("failure probe count above cap");
`endif

endmodule

`default_nettype wire
